FILE: design/bfe_pkg.sv
// blowfish block encrypt: shared types, constants and codes
// no dependencies; used by the top, round and sequencer modules
`timescale 1ns / 1ps

package bfe_pkg;

   localparam int DEF_ROUNDS = 16;
   localparam int WORD_W     = 32;
   localparam int BLOCK_W    = 64;
   localparam int IDX_W      = 8;
   localparam int BOX_W      = 2;
   localparam int MODE_W     = 2;
   localparam int SBOX_DEPTH = 256;
   localparam int NUM_BOXES  = 4;
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_USER_W = 1;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD_P  = 2'd0,
      MODE_LOAD_S  = 2'd1,
      MODE_XOR_P   = 2'd2,
      MODE_ENCRYPT = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_ROUND,
      ST_FINAL,
      ST_XOR
   } state_type;

   typedef struct packed {
      logic idle;
      logic start;
      logic round;
      logic last;
      logic fin;
      logic xor_st;
   } ctrl_type;

endpackage

FILE: design/blowfish_block_encrypt_top.sv
// blowfish block encrypt top: table rams, half-block registers, response register
// depends on bfe_pkg, bfe_ram, bfe_round, bfe_seq
//
// channel | dir | signals                             | contents
// req     | in  | req_tvalid req_tready req_tdata/user | command request
// rsp     | out | rsp_tvalid rsp_tready rsp_tdata/user | ciphertext or write ack
//
// encrypt: a start step for the first p word and s-box reads, one round per cycle, then a
// final step for the last p word that loads the response register
// load p and load s: response the cycle after accept; xor into p: a read and then a
// write of the p ram; one request at a time
// reset clears the sequencer and response valid; the tables keep their contents
// a held response stalls the sequencer at its last step and blocks new requests
`timescale 1ns / 1ps

module blowfish_block_encrypt_top #(
   parameter int ROUNDS = bfe_pkg::DEF_ROUNDS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // table_index[7:0], box_select[9:8], data_word[41:10], block_in[105:42], zero pad
   input  logic [bfe_pkg::REQ_DATA_W-1:0]   req_tdata,
   // mode[1:0]
   input  logic [bfe_pkg::MODE_W-1:0]       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // block_out[63:0]
   output logic [bfe_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // is_cipher[0]
   output logic [bfe_pkg::RSP_USER_W-1:0]   rsp_tuser
);

   localparam int PDepth = ROUNDS + 2;
   localparam int PAW    = $clog2(PDepth);
   localparam int CntW   = $clog2(ROUNDS);
   localparam int SAW    = $clog2(bfe_pkg::SBOX_DEPTH);
   localparam logic [bfe_pkg::IDX_W-1:0] PLimit = PDepth[bfe_pkg::IDX_W-1:0];

   // request fields
   logic [bfe_pkg::IDX_W-1:0]   table_index;
   logic [bfe_pkg::BOX_W-1:0]   box_select;
   logic [bfe_pkg::WORD_W-1:0]  data_word;
   logic [bfe_pkg::BLOCK_W-1:0] block_in;
   bfe_pkg::mode_type           mode;

   assign table_index = req_tdata[7:0];
   assign box_select  = req_tdata[9:8];
   assign data_word   = req_tdata[41:10];
   assign block_in    = req_tdata[105:42];
   assign mode        = bfe_pkg::mode_type'(req_tuser);

   bfe_pkg::ctrl_type ctrl;
   logic [CntW-1:0]   round_cnt;
   logic              req_fire;
   logic              rsp_free;
   logic              idx_ok;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [bfe_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [bfe_pkg::RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;
   logic                           rsp_load;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = ctrl.idle && rsp_free;
   assign req_fire   = req_tvalid && req_tready;
   assign idx_ok     = (table_index < PLimit);

   bfe_seq #(
      .ROUNDS (ROUNDS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_mode  (mode),
      .rsp_free  (rsp_free),
      .ctrl      (ctrl),
      .round_cnt (round_cnt)
   );

   // half-block registers and xor bookkeeping
   logic [bfe_pkg::WORD_W-1:0] left_ff, left_in;
   logic [bfe_pkg::WORD_W-1:0] right_ff, right_in;
   logic [PAW-1:0]             pidx_ff, pidx_in;
   logic                       pok_ff, pok_in;
   logic [bfe_pkg::WORD_W-1:0] left_next, right_next;

   // p-array ram
   logic                       p_wr_en;
   logic [PAW-1:0]             p_wr_addr, p_rd_addr;
   logic [bfe_pkg::WORD_W-1:0] p_wr_data, p_rd_data;

   // s-box rams
   logic [bfe_pkg::WORD_W-1:0] s_rd_data [bfe_pkg::NUM_BOXES];
   logic [SAW-1:0]             s_rd_addr [bfe_pkg::NUM_BOXES];
   logic                       s_wr_en   [bfe_pkg::NUM_BOXES];

   always_comb begin
      priority if (ctrl.idle) begin
         p_rd_addr = (mode == bfe_pkg::MODE_XOR_P) ? table_index[PAW-1:0] : '0;
      end else if (ctrl.start) begin
         p_rd_addr = PAW'(1);
      end else if (ctrl.round) begin
         p_rd_addr = PAW'(round_cnt) + PAW'(2);
      end else if (ctrl.fin) begin
         p_rd_addr = PAW'(ROUNDS + 1);
      end else begin
         p_rd_addr = pidx_ff;
      end
   end

   always_comb begin
      p_wr_en   = 1'b0;
      p_wr_addr = table_index[PAW-1:0];
      p_wr_data = data_word;
      if (req_fire && (mode == bfe_pkg::MODE_LOAD_P) && idx_ok) begin
         p_wr_en = 1'b1;
      end else if (ctrl.xor_st && rsp_free && pok_ff) begin
         p_wr_en   = 1'b1;
         p_wr_addr = pidx_ff;
         p_wr_data = p_rd_data ^ right_ff;
      end
   end

   bfe_ram #(
      .WIDTH (bfe_pkg::WORD_W),
      .DEPTH (PDepth)
   ) u_p_ram (
      .clock   (clock),
      .wr_en   (p_wr_en),
      .wr_addr (p_wr_addr),
      .wr_data (p_wr_data),
      .rd_addr (p_rd_addr),
      .rd_data (p_rd_data)
   );

   for (genvar b = 0; b < bfe_pkg::NUM_BOXES; b++) begin : g_sbox
      // box 0 takes the top byte of the left half
      assign s_rd_addr[b] = left_in[bfe_pkg::WORD_W-1-8*b -: 8];
      assign s_wr_en[b]   = req_fire && (mode == bfe_pkg::MODE_LOAD_S)
                            && (box_select == bfe_pkg::BOX_W'(b));

      bfe_ram #(
         .WIDTH (bfe_pkg::WORD_W),
         .DEPTH (bfe_pkg::SBOX_DEPTH)
      ) u_s_ram (
         .clock   (clock),
         .wr_en   (s_wr_en[b]),
         .wr_addr (table_index),
         .wr_data (data_word),
         .rd_addr (s_rd_addr[b]),
         .rd_data (s_rd_data[b])
      );
   end

   bfe_round u_round (
      .s0_word    (s_rd_data[0]),
      .s1_word    (s_rd_data[1]),
      .s2_word    (s_rd_data[2]),
      .s3_word    (s_rd_data[3]),
      .left       (left_ff),
      .right      (right_ff),
      .p_word     (p_rd_data),
      .last       (ctrl.last),
      .left_next  (left_next),
      .right_next (right_next)
   );

   always_comb begin
      left_in  = left_ff;
      right_in = right_ff;
      pidx_in  = pidx_ff;
      pok_in   = pok_ff;
      priority if (req_fire) begin
         left_in  = block_in[bfe_pkg::BLOCK_W-1:bfe_pkg::WORD_W];
         right_in = (mode == bfe_pkg::MODE_ENCRYPT) ?
                    block_in[bfe_pkg::WORD_W-1:0] : data_word;
         pidx_in  = table_index[PAW-1:0];
         pok_in   = idx_ok;
      end else if (ctrl.start) begin
         left_in = left_ff ^ p_rd_data;
      end else if (ctrl.round) begin
         left_in  = left_next;
         right_in = right_next;
      end else begin
         left_in = left_ff;
      end
   end

   always_ff @(posedge clock) begin
      left_ff  <= left_in;
      right_ff <= right_in;
      pidx_ff  <= pidx_in;
      pok_ff   <= pok_in;
   end

   // response register
   assign rsp_load = (ctrl.fin && rsp_free) || (ctrl.xor_st && rsp_free)
                     || (req_fire && ((mode == bfe_pkg::MODE_LOAD_P)
                                      || (mode == bfe_pkg::MODE_LOAD_S)));

   always_comb begin
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      if (rsp_load) begin
         if (ctrl.fin) begin
            rsp_data_in = {left_ff ^ p_rd_data, right_ff};
            rsp_user_in = bfe_pkg::RSP_USER_W'(1);
         end else begin
            rsp_data_in = '0;
            rsp_user_in = '0;
         end
      end
      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_enc_start: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (mode == bfe_pkg::MODE_ENCRYPT)) |=> ctrl.start)
      else $error("encrypt request did not start the rounds");

   a_round_span: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> ##(ROUNDS + 1) ctrl.fin)
      else $error("round sequence length wrong");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      ctrl.round |-> (round_cnt <= CntW'(ROUNDS - 1)))
      else $error("round counter out of range");

   a_cipher_rsp: assert property (@(posedge clock) disable iff (reset)
      (ctrl.fin && rsp_free) |=> (rsp_tvalid && rsp_tuser[0]))
      else $error("ciphertext response not presented");

endmodule

FILE: design/bfe_ram.sv
// generic simple dual-port ram, one write and one registered read port
// depends on nothing
`timescale 1ns / 1ps

module bfe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/bfe_round.sv
// blowfish round unit: f function over four s-box words and the half swap
// depends on bfe_pkg
`timescale 1ns / 1ps

module bfe_round (
   input  logic [bfe_pkg::WORD_W-1:0] s0_word,
   input  logic [bfe_pkg::WORD_W-1:0] s1_word,
   input  logic [bfe_pkg::WORD_W-1:0] s2_word,
   input  logic [bfe_pkg::WORD_W-1:0] s3_word,
   input  logic [bfe_pkg::WORD_W-1:0] left,
   input  logic [bfe_pkg::WORD_W-1:0] right,
   input  logic [bfe_pkg::WORD_W-1:0] p_word,
   input  logic                       last,
   output logic [bfe_pkg::WORD_W-1:0] left_next,
   output logic [bfe_pkg::WORD_W-1:0] right_next
);

   logic [bfe_pkg::WORD_W-1:0] sum_ab;
   logic [bfe_pkg::WORD_W-1:0] f_word;
   logic [bfe_pkg::WORD_W-1:0] mix;

   always_comb begin
      sum_ab = s0_word + s1_word;
      f_word = (sum_ab ^ s2_word) + s3_word;
      mix    = right ^ f_word ^ p_word;
      // last round keeps the halves unswapped and whitens the right half
      if (last) begin
         left_next  = left;
         right_next = mix;
      end else begin
         left_next  = mix;
         right_next = left;
      end
   end

endmodule

FILE: design/bfe_seq.sv
// blowfish sequencer: request state machine and round counter
// depends on bfe_pkg
`timescale 1ns / 1ps

module bfe_seq #(
   parameter int ROUNDS = bfe_pkg::DEF_ROUNDS,
   localparam int CntW = $clog2(ROUNDS)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_fire,
   input  bfe_pkg::mode_type  req_mode,
   input  logic               rsp_free,
   output bfe_pkg::ctrl_type  ctrl,
   output logic [CntW-1:0]    round_cnt
);

   bfe_pkg::state_type state_ff, state_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic               cnt_last;

   assign cnt_last = (cnt_ff == CntW'(ROUNDS - 1));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         bfe_pkg::ST_IDLE: begin
            if (req_fire) begin
               priority if (req_mode == bfe_pkg::MODE_ENCRYPT) begin
                  state_in = bfe_pkg::ST_START;
               end else if (req_mode == bfe_pkg::MODE_XOR_P) begin
                  state_in = bfe_pkg::ST_XOR;
               end else begin
                  state_in = bfe_pkg::ST_IDLE;
               end
            end
         end
         bfe_pkg::ST_START: begin
            state_in = bfe_pkg::ST_ROUND;
            cnt_in   = '0;
         end
         bfe_pkg::ST_ROUND: begin
            if (cnt_last) begin
               state_in = bfe_pkg::ST_FINAL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         bfe_pkg::ST_FINAL, bfe_pkg::ST_XOR: begin
            if (rsp_free) begin
               state_in = bfe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bfe_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl.idle   = (state_ff == bfe_pkg::ST_IDLE);
      ctrl.start  = (state_ff == bfe_pkg::ST_START);
      ctrl.round  = (state_ff == bfe_pkg::ST_ROUND);
      ctrl.last   = (state_ff == bfe_pkg::ST_ROUND) && cnt_last;
      ctrl.fin    = (state_ff == bfe_pkg::ST_FINAL);
      ctrl.xor_st = (state_ff == bfe_pkg::ST_XOR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfe_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign round_cnt = cnt_ff;

endmodule

FILE: tb/sv/testbench.sv
// self-checking testbench for blowfish_block_encrypt_top: fills the p and s tables,
// runs directed and random load, key-xor and encrypt requests under random idling
// depends on bfe_pkg and the blowfish_block_encrypt_top rtl
`timescale 1ns / 1ps

module testbench;

   localparam int ROUNDS     = bfe_pkg::DEF_ROUNDS;
   localparam int WORD_W     = bfe_pkg::WORD_W;
   localparam int BLOCK_W    = bfe_pkg::BLOCK_W;
   localparam int IDX_W      = bfe_pkg::IDX_W;
   localparam int BOX_W      = bfe_pkg::BOX_W;
   localparam int MODE_W     = bfe_pkg::MODE_W;
   localparam int SBOX_DEPTH = bfe_pkg::SBOX_DEPTH;
   localparam int REQ_DATA_W = bfe_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W = bfe_pkg::RSP_DATA_W;
   localparam int RSP_USER_W = bfe_pkg::RSP_USER_W;
   localparam int P_ENTRIES  = ROUNDS + 2;
   localparam int S_ENTRIES  = bfe_pkg::NUM_BOXES * SBOX_DEPTH;
   localparam int HOLD_OFF   = 600;

   typedef struct {
      bit [BLOCK_W-1:0] block;
      bit               is_cipher;
   } cipher_result_type;

   class block_scoreboard;
      bit [WORD_W-1:0]   p_words [P_ENTRIES];
      bit [WORD_W-1:0]   s_words [S_ENTRIES];
      cipher_result_type results_due [$];
      int unsigned       mismatches;

      function bit [WORD_W-1:0] round_mix(bit [WORD_W-1:0] x);
         bit [WORD_W-1:0] sum;
         sum = s_words[{2'd0, x[31:24]}] + s_words[{2'd1, x[23:16]}];
         sum = sum ^ s_words[{2'd2, x[15:8]}];
         return sum + s_words[{2'd3, x[7:0]}];
      endfunction

      function bit [BLOCK_W-1:0] encipher(bit [BLOCK_W-1:0] plain);
         bit [WORD_W-1:0] left;
         bit [WORD_W-1:0] right;
         bit [WORD_W-1:0] swap;
         left  = plain[63:32];
         right = plain[31:0];
         for (int i = 0; i < ROUNDS; i++) begin
            left  = left ^ p_words[i];
            right = right ^ round_mix(left);
            swap  = left;
            left  = right;
            right = swap;
         end
         right = left ^ p_words[ROUNDS];
         left  = swap ^ p_words[ROUNDS + 1];
         return {left, right};
      endfunction

      function void note_request(bfe_pkg::mode_type mode, bit [IDX_W-1:0] idx,
                                 bit [BOX_W-1:0] box, bit [WORD_W-1:0] word,
                                 bit [BLOCK_W-1:0] plain);
         cipher_result_type res;
         res.block     = '0;
         res.is_cipher = 1'b0;
         unique case (mode)
            bfe_pkg::MODE_LOAD_P: begin
               if (idx < P_ENTRIES) p_words[idx] = word;
            end
            bfe_pkg::MODE_LOAD_S: begin
               s_words[{box, idx}] = word;
            end
            bfe_pkg::MODE_XOR_P: begin
               if (idx < P_ENTRIES) p_words[idx] = p_words[idx] ^ word;
            end
            default: begin
               res.block     = encipher(plain);
               res.is_cipher = 1'b1;
            end
         endcase
         results_due.push_back(res);
      endfunction

      function void check_response(logic [BLOCK_W-1:0] block, logic cipher_flag);
         cipher_result_type res;
         if (results_due.size() == 0) begin
            $error("unexpected response: block_out %h is_cipher %b", block, cipher_flag);
            mismatches++;
         end else begin
            res = results_due.pop_front();
            if (block !== res.block) begin
               $error("block_out: expected %h, actual %h", res.block, block);
               mismatches++;
            end
            if (cipher_flag !== res.is_cipher) begin
               $error("is_cipher: expected %b, actual %b", res.is_cipher, cipher_flag);
               mismatches++;
            end
         end
      endfunction

      function int outstanding();
         return results_due.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [MODE_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   block_scoreboard sb = new;
   int unsigned     burst_left = 0;
   bit              hold_off_request = 1'b0;

   always #5 clock = ~clock;

   blowfish_block_encrypt_top #(
      .ROUNDS(ROUNDS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   function bit [WORD_W-1:0] rand_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   function bit [BLOCK_W-1:0] rand_block();
      return {rand_word(), rand_word()};
   endfunction

   function bit [IDX_W-1:0] rand_p_index();
      if ($urandom_range(0, 7) == 0) return IDX_W'($urandom_range(P_ENTRIES, 255));
      return IDX_W'($urandom_range(0, P_ENTRIES - 1));
   endfunction

   task automatic send_request(bfe_pkg::mode_type mode, bit [IDX_W-1:0] idx,
                               bit [BOX_W-1:0] box, bit [WORD_W-1:0] word,
                               bit [BLOCK_W-1:0] plain);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {6'b0, plain, word, box, idx};
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_request(mode, idx, box, word, plain);
      burst_left--;
   endtask

   task automatic random_request();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)
         send_request(bfe_pkg::MODE_ENCRYPT, IDX_W'($urandom), BOX_W'($urandom),
                      rand_word(), rand_block());
      else if (pick < 65)
         send_request(bfe_pkg::MODE_LOAD_S, IDX_W'($urandom), BOX_W'($urandom),
                      rand_word(), rand_block());
      else if (pick < 80)
         send_request(bfe_pkg::MODE_LOAD_P, rand_p_index(), BOX_W'($urandom),
                      rand_word(), rand_block());
      else
         send_request(bfe_pkg::MODE_XOR_P, rand_p_index(), BOX_W'($urandom),
                      rand_word(), rand_block());
   endtask

   // response side: ready patterns, plus one long hold-off on request
   initial begin
      int unsigned kind;
      int unsigned span;
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            repeat (HOLD_OFF) begin
               @(posedge clock);
               rsp_tready <= 1'b0;
            end
         end else begin
            kind = $urandom_range(0, 3);
            span = $urandom_range(16, 160);
            for (int i = 0; i < span; i++) begin
               @(posedge clock);
               case (kind)
                  0: rsp_tready <= 1'b1;
                  1: rsp_tready <= 1'($urandom_range(0, 1));
                  2: rsp_tready <= ($urandom_range(0, 7) == 0);
                  default: rsp_tready <= i[1];
               endcase
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser[0]);
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill every table entry so later reads never hit unwritten words
      for (int i = 0; i < P_ENTRIES; i++)
         send_request(bfe_pkg::MODE_LOAD_P, IDX_W'(i), BOX_W'($urandom), rand_word(),
                      rand_block());
      for (int i = 0; i < S_ENTRIES; i++)
         send_request(bfe_pkg::MODE_LOAD_S, IDX_W'(i % SBOX_DEPTH), BOX_W'(i / SBOX_DEPTH),
                      rand_word(), rand_block());

      // directed corners
      send_request(bfe_pkg::MODE_LOAD_P, 8'd0, 2'd0, 32'h0, 64'h0);
      send_request(bfe_pkg::MODE_LOAD_P, 8'd17, 2'd3, 32'hffff_ffff, '1);
      send_request(bfe_pkg::MODE_LOAD_P, 8'd18, 2'd1, 32'h1234_5678, 64'h0);
      send_request(bfe_pkg::MODE_LOAD_P, 8'd255, 2'd2, 32'hffff_ffff, '1);
      send_request(bfe_pkg::MODE_XOR_P, 8'd255, 2'd3, 32'hffff_ffff, '1);
      send_request(bfe_pkg::MODE_XOR_P, 8'd17, 2'd0, 32'hffff_ffff, 64'h0);
      send_request(bfe_pkg::MODE_XOR_P, 8'd0, 2'd1, 32'h0, 64'h0);
      send_request(bfe_pkg::MODE_XOR_P, 8'd18, 2'd2, 32'hdead_beef, 64'h0);
      send_request(bfe_pkg::MODE_LOAD_S, 8'd0, 2'd0, 32'h0, 64'h0);
      send_request(bfe_pkg::MODE_LOAD_S, 8'd255, 2'd3, 32'hffff_ffff, '1);
      send_request(bfe_pkg::MODE_LOAD_S, 8'd128, 2'd2, 32'h8000_0001, '1);
      send_request(bfe_pkg::MODE_LOAD_S, 8'd127, 2'd1, 32'h7fff_fffe, 64'h0);
      send_request(bfe_pkg::MODE_ENCRYPT, 8'd0, 2'd0, 32'h0, 64'h0);
      send_request(bfe_pkg::MODE_ENCRYPT, 8'd255, 2'd3, 32'hffff_ffff, '1);
      send_request(bfe_pkg::MODE_ENCRYPT, 8'd255, 2'd3, 32'hffff_ffff,
                   64'h0123_4567_89ab_cdef);
      send_request(bfe_pkg::MODE_ENCRYPT, 8'd0, 2'd0, 32'h0, 64'hffff_ffff_0000_0000);
      send_request(bfe_pkg::MODE_ENCRYPT, 8'd17, 2'd1, 32'h5555_aaaa,
                   64'h0000_0000_ffff_ffff);
      send_request(bfe_pkg::MODE_ENCRYPT, 8'd18, 2'd2, 32'haaaa_5555,
                   64'h8000_0000_0000_0001);

      // random mix, with one long response stall early on
      hold_off_request = 1'b1;
      repeat (740) random_request();

      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (ROUNDS + 8) @(posedge clock);
      if (sb.mismatches == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

   initial begin
      #10ms;
      $display("testbench: FAIL");
      $finish;
   end

endmodule
